// ===== design/stsub_pkg.sv =====
package stsub_pkg;

  localparam int unsigned FRAC_BITS  = 14;
  localparam int unsigned EXTRA_BITS = 14;
  localparam int unsigned VW         = 16;
  localparam int unsigned MAG_W      = VW + 1;
  localparam int unsigned SQ_W       = 2 * MAG_W;
  localparam int unsigned N_W        = SQ_W + 2;
  localparam int unsigned DW         = 64;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned QW         = FRAC_BITS + 1;
  // sum, square, accumulate, root steps, saturation check, divide steps, output
  localparam int unsigned MID_LAT    = 3 + SQRT_STEPS + 1 + QW + 1;

  localparam logic [1:0] TRI_0 = 2'd0;
  localparam logic [1:0] TRI_1 = 2'd1;
  localparam logic [1:0] TRI_2 = 2'd2;
  localparam logic [1:0] TRI_3 = 2'd3;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] z;
  } vec_t;

  typedef struct packed {
    vec_t a;
    vec_t b;
    vec_t c;
  } tri_t;

  typedef struct packed {
    vec_t a;
    vec_t b;
    vec_t c;
    vec_t ab;
    vec_t bc;
    vec_t ca;
  } split_t;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic                  zero;
  } side_t;

endpackage

// ===== design/stsub_in_if.sv =====
interface stsub_in_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  a_x, a_y, a_z;
  logic signed [15:0]  b_x, b_y, b_z;
  logic signed [15:0]  c_x, c_y, c_z;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                output ready);
endinterface

// ===== design/stsub_out_if.sv =====
interface stsub_out_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  p_x, p_y, p_z;
  logic signed [15:0]  q_x, q_y, q_z;
  logic signed [15:0]  r_x, r_y, r_z;
  logic                last_tri;

  modport source (output valid, p_x, p_y, p_z, q_x, q_y, q_z, r_x, r_y, r_z,
                  last_tri, input ready);
  modport sink (input valid, p_x, p_y, p_z, q_x, q_y, q_z, r_x, r_y, r_z,
                last_tri, output ready);
endinterface

// ===== design/sphere_triangle_subdivider_top.sv =====
// Flow: the output port gives four sub-triangles per input triangle, and the
//   whole pipeline stalls until the last of them is taken; otherwise it takes
//   a new item every cycle.
// Reset: rst_ni asynchronous, active low; clears valid bits and the output
//   sequencer only, datapath registers are not reset.
module sphere_triangle_subdivider_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  stsub_in_if.sink    in_i,
  stsub_out_if.source out_o
);

  localparam int unsigned LAT = stsub_pkg::MID_LAT;

  // one global advance: the whole pipeline moves when the sequencer can load
  logic                en;
  stsub_pkg::tri_t     tri_in;
  logic                vld_q  [LAT];
  stsub_pkg::tri_t     corn_q [LAT];
  stsub_pkg::vec_t     ab, bc, ca;
  stsub_pkg::split_t   split;

  assign tri_in.a = '{x: in_i.a_x, y: in_i.a_y, z: in_i.a_z};
  assign tri_in.b = '{x: in_i.b_x, y: in_i.b_y, z: in_i.b_z};
  assign tri_in.c = '{x: in_i.c_x, y: in_i.c_y, z: in_i.c_z};

  assign in_i.ready = en;

  // valid bits, aligned with the edge units
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_i.valid;
      for (int i = 1; i < LAT; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // corners ride alongside untouched
  always_ff @(posedge clk_i) begin
    if (en) begin
      corn_q[0] <= tri_in;
      for (int i = 1; i < LAT; i++) corn_q[i] <= corn_q[i-1];
    end
  end

  stsub_mid u_mid_ab (.clk_i, .en_i(en), .u_i(tri_in.a), .v_i(tri_in.b), .m_o(ab));
  stsub_mid u_mid_bc (.clk_i, .en_i(en), .u_i(tri_in.b), .v_i(tri_in.c), .m_o(bc));
  stsub_mid u_mid_ca (.clk_i, .en_i(en), .u_i(tri_in.c), .v_i(tri_in.a), .m_o(ca));

  assign split.a  = corn_q[LAT-1].a;
  assign split.b  = corn_q[LAT-1].b;
  assign split.c  = corn_q[LAT-1].c;
  assign split.ab = ab;
  assign split.bc = bc;
  assign split.ca = ca;

  // four output transactions per loaded item
  stsub_ser u_ser (
    .clk_i,
    .rst_ni,
    .ld_valid_i (vld_q[LAT-1]),
    .ld_data_i  (split),
    .ld_ready_o (en),
    .out_o
  );

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.last_tri) |-> in_i.ready)
    else $error("pipeline not advancing after final sub-triangle");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while output stalled");

  a_pipe_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q[LAT-1]))
    else $error("pipeline valid moved while stalled");

endmodule

// ===== design/stsub_mid.sv =====
module stsub_mid (
  input  logic                clk_i,
  input  logic                en_i,
  input  stsub_pkg::vec_t     u_i,
  input  stsub_pkg::vec_t     v_i,
  output stsub_pkg::vec_t     m_o
);

  localparam int unsigned MW = stsub_pkg::MAG_W;
  localparam int unsigned DW = stsub_pkg::DW;
  localparam int unsigned QW = stsub_pkg::QW;
  localparam int unsigned NS = stsub_pkg::SQRT_STEPS;
  localparam logic [QW-1:0] LIM = QW'(1) << stsub_pkg::FRAC_BITS;

  logic [2:0][MW-1:0]          sum_mag;
  logic [2:0]                  sum_neg;
  logic [2:0][MW-1:0]          s_u, s_v;
  logic [2:0][MW-1:0]          s_sum;

  stsub_pkg::side_t            side1_q;
  stsub_pkg::side_t            side2_q;
  logic [2:0][stsub_pkg::SQ_W-1:0] sq_q;
  logic [stsub_pkg::N_W-1:0]   n_sum;

  stsub_pkg::side_t            sside_q [NS+1];
  logic [DW-1:0]               rem_q   [NS+1];
  logic [DW-1:0]               res_q   [NS+1];

  stsub_pkg::side_t            dside_q [QW+1];
  logic [DW-1:0]               dlen_q  [QW+1];
  logic [2:0][DW-1:0]          drem_q  [QW+1];
  logic [2:0][QW-1:0]          dq_q    [QW+1];
  logic [2:0]                  sat_q   [QW+1];

  stsub_pkg::vec_t             m_q;

  // edge sum and magnitude; index 2 is x, 1 is y, 0 is z
  always_comb begin
    s_u = {{u_i.x[15], u_i.x}, {u_i.y[15], u_i.y}, {u_i.z[15], u_i.z}};
    s_v = {{v_i.x[15], v_i.x}, {v_i.y[15], v_i.y}, {v_i.z[15], v_i.z}};
    for (int c = 0; c < 3; c++) begin
      s_sum[c]   = s_u[c] + s_v[c];
      sum_neg[c] = s_sum[c][MW-1];
      sum_mag[c] = sum_neg[c] ? (~s_sum[c] + MW'(1)) : s_sum[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q.mag  <= sum_mag;
      side1_q.neg  <= sum_neg;
      side1_q.zero <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side2_q <= side1_q;
      for (int c = 0; c < 3; c++) begin
        sq_q[c] <= side1_q.mag[c] * side1_q.mag[c];
      end
    end
  end

  assign n_sum = stsub_pkg::N_W'(sq_q[0]) + stsub_pkg::N_W'(sq_q[1])
               + stsub_pkg::N_W'(sq_q[2]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sside_q[0] <= '{mag: side2_q.mag, neg: side2_q.neg, zero: (n_sum == '0)};
      rem_q[0]   <= DW'(n_sum) << (2 * stsub_pkg::EXTRA_BITS);
      res_q[0]   <= '0;
    end
  end

  // square root, one result bit per stage
  for (genvar i = 0; i < NS; i++) begin : g_sqrt
    localparam logic [DW-1:0] BIT = DW'(1) << (DW - 2 - 2 * i);
    logic [DW-1:0] trial;
    assign trial = res_q[i] + BIT;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sside_q[i+1] <= sside_q[i];
        if (rem_q[i] >= trial) begin
          rem_q[i+1] <= rem_q[i] - trial;
          res_q[i+1] <= (res_q[i] >> 1) + BIT;
        end else begin
          rem_q[i+1] <= rem_q[i];
          res_q[i+1] <= res_q[i] >> 1;
        end
      end
    end
  end

  // numerator and saturation check: q > lim iff num >= (lim+1)*len
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dside_q[0] <= sside_q[NS];
      dlen_q[0]  <= res_q[NS];
      for (int c = 0; c < 3; c++) begin
        drem_q[0][c] <= ((DW'(sside_q[NS].mag[c]))
                         << (stsub_pkg::FRAC_BITS + stsub_pkg::EXTRA_BITS))
                        + (res_q[NS] >> 1);
        dq_q[0][c]   <= '0;
        sat_q[0][c]  <= (((DW'(sside_q[NS].mag[c]))
                          << (stsub_pkg::FRAC_BITS + stsub_pkg::EXTRA_BITS))
                         + (res_q[NS] >> 1))
                        >= ((res_q[NS] << stsub_pkg::FRAC_BITS) + res_q[NS]);
      end
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int unsigned P = QW - 1 - k;
    logic [DW-1:0] dsub;
    assign dsub = dlen_q[k] << P;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dside_q[k+1] <= dside_q[k];
        dlen_q[k+1]  <= dlen_q[k];
        sat_q[k+1]   <= sat_q[k];
        for (int c = 0; c < 3; c++) begin
          if (drem_q[k][c] >= dsub) begin
            drem_q[k+1][c]  <= drem_q[k][c] - dsub;
            dq_q[k+1][c]    <= dq_q[k][c] | (QW'(1) << P);
          end else begin
            drem_q[k+1][c]  <= drem_q[k][c];
            dq_q[k+1][c]    <= dq_q[k][c];
          end
        end
      end
    end
  end

  // sign, clamp to field range
  localparam int unsigned VW_LOC = stsub_pkg::VW;
  logic [2:0][VW_LOC-1:0] comp;
  always_comb begin
    logic [31:0] qx;
    for (int c = 0; c < 3; c++) begin
      qx = 32'(sat_q[QW][c] ? LIM : dq_q[QW][c]);
      if (dside_q[QW].zero) begin
        comp[c] = '0;
      end else if (!dside_q[QW].neg[c]) begin
        comp[c] = (qx > 32'd32767) ? 16'h7fff : qx[15:0];
      end else begin
        comp[c] = (qx > 32'd32768) ? 16'h8000 : 16'(~qx + 32'd1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q.x <= comp[2];
      m_q.y <= comp[1];
      m_q.z <= comp[0];
    end
  end

  assign m_o = m_q;

endmodule

// ===== design/stsub_ser.sv =====
module stsub_ser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 ld_valid_i,
  input  stsub_pkg::split_t    ld_data_i,
  output logic                 ld_ready_o,
  stsub_out_if.source          out_o
);

  logic                busy_q;
  logic [1:0]          cnt_q;
  stsub_pkg::split_t   item_q;
  stsub_pkg::vec_t     pv, qv, rv;
  logic                fire;

  assign fire       = busy_q && out_o.ready;
  assign ld_ready_o = !busy_q || (fire && cnt_q == stsub_pkg::TRI_3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= stsub_pkg::TRI_0;
    end else if (ld_ready_o) begin
      busy_q <= ld_valid_i;
      cnt_q  <= stsub_pkg::TRI_0;
    end else if (fire) begin
      cnt_q  <= cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_ready_o && ld_valid_i) begin
      item_q <= ld_data_i;
    end
  end

  always_comb begin
    case (cnt_q)
      stsub_pkg::TRI_0: begin pv = item_q.a;  qv = item_q.ab; rv = item_q.ca; end
      stsub_pkg::TRI_1: begin pv = item_q.ab; qv = item_q.b;  rv = item_q.bc; end
      stsub_pkg::TRI_2: begin pv = item_q.ab; qv = item_q.bc; rv = item_q.ca; end
      default:          begin pv = item_q.ca; qv = item_q.bc; rv = item_q.c;  end
    endcase
  end

  assign out_o.valid    = busy_q;
  assign out_o.p_x      = pv.x;
  assign out_o.p_y      = pv.y;
  assign out_o.p_z      = pv.z;
  assign out_o.q_x      = qv.x;
  assign out_o.q_y      = qv.y;
  assign out_o.q_z      = qv.z;
  assign out_o.r_x      = rv.x;
  assign out_o.r_y      = rv.y;
  assign out_o.r_z      = rv.z;
  assign out_o.last_tri = (cnt_q == stsub_pkg::TRI_3);

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int LATENCY = stsub_pkg::FRAC_BITS + 39;

  typedef struct packed {
    logic signed [15:0] x, y, z;
  } pt_t;

  typedef struct packed {
    pt_t p, q, r;
    logic last_tri;
  } subtri_t;

  typedef struct packed {
    pt_t a, b, c;
  } face_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  stsub_in_if  in_if ();
  stsub_out_if out_if ();

  sphere_triangle_subdivider_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  always #5 clk_i = ~clk_i;

  face_t   face_q[$];      // triangles waiting to be offered
  subtri_t subtri_q[$];    // predicted sub-triangles, oldest first
  int      n_errors = 0;
  bit      stim_done = 1'b0;
  bit      hold_off = 1'b0; // long receiver hold-off window

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  task automatic queue_face(input face_t f);
    face_q = {face_q, f};
  endtask

  task automatic queue_subtri(input subtri_t s);
    subtri_q = {subtri_q, s};
  endtask

  function automatic logic [63:0] root64(input logic [63:0] n);
    logic [63:0] res, bit_w, rem;
    rem = n;
    res = '0;
    bit_w = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bit_w) begin
        rem = rem - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  // normalised edge midpoint; cancelled sums give the origin
  function automatic pt_t edge_mid(input pt_t u, input pt_t v);
    longint s[3], mag, n, quo, lim, r;
    logic [63:0] len;
    pt_t m;
    s[0] = longint'(u.x) + longint'(v.x);
    s[1] = longint'(u.y) + longint'(v.y);
    s[2] = longint'(u.z) + longint'(v.z);
    n = s[0]*s[0] + s[1]*s[1] + s[2]*s[2];
    lim = longint'(1) << stsub_pkg::FRAC_BITS;
    if (n == 0) return '0;
    len = root64(64'(n) << 28);
    for (int i = 0; i < 3; i++) begin
      mag = s[i] < 0 ? -s[i] : s[i];
      quo = longint'(((64'(mag) << (stsub_pkg::FRAC_BITS + 14)) + (len >> 1)) / len);
      if (quo > lim) quo = lim;
      r = s[i] < 0 ? -quo : quo;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      if (i == 0) m.x = 16'(r);
      else if (i == 1) m.y = 16'(r);
      else m.z = 16'(r);
    end
    return m;
  endfunction

  task automatic predict_split(input face_t f);
    pt_t ab, bc, ca;
    ab = edge_mid(f.a, f.b);
    bc = edge_mid(f.b, f.c);
    ca = edge_mid(f.c, f.a);
    queue_subtri({f.a, ab, ca, 1'b0});
    queue_subtri({ab, f.b, bc, 1'b0});
    queue_subtri({ab, bc, ca, 1'b0});
    queue_subtri({ca, bc, f.c, 1'b1});
  endtask

  // driver: offer queued triangles with random gaps
  int drv_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      {in_if.a_x, in_if.a_y, in_if.a_z} <= '0;
      {in_if.b_x, in_if.b_y, in_if.b_z} <= '0;
      {in_if.c_x, in_if.c_y, in_if.c_z} <= '0;
    end else begin
      automatic bit busy = in_if.valid && !in_if.ready;
      if (in_if.valid && in_if.ready) begin
        predict_split({in_if.a_x, in_if.a_y, in_if.a_z, in_if.b_x, in_if.b_y,
                       in_if.b_z, in_if.c_x, in_if.c_y, in_if.c_z});
        void'(face_q.pop_front());
        drv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      end
      if (!busy) begin
        if (drv_gap > 0) begin
          drv_gap--;
          in_if.valid <= 1'b0;
        end else if (face_q.size() > 0) begin
          in_if.valid <= 1'b1;
          {in_if.a_x, in_if.a_y, in_if.a_z} <= face_q[0].a;
          {in_if.b_x, in_if.b_y, in_if.b_z} <= face_q[0].b;
          {in_if.c_x, in_if.c_y, in_if.c_z} <= face_q[0].c;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver stall while the driver keeps offering
  initial begin
    wait (rst_ni);
    repeat (200) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // monitor: random back-pressure, long hold-off on request
  int mon_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (subtri_q.size() == 0) begin
          report_mismatch("unexpected sub-triangle p_x", out_if.p_x, '0);
        end else begin
          automatic subtri_t w = subtri_q.pop_front();
          if (out_if.p_x !== w.p.x) report_mismatch("p_x", out_if.p_x, w.p.x);
          if (out_if.p_y !== w.p.y) report_mismatch("p_y", out_if.p_y, w.p.y);
          if (out_if.p_z !== w.p.z) report_mismatch("p_z", out_if.p_z, w.p.z);
          if (out_if.q_x !== w.q.x) report_mismatch("q_x", out_if.q_x, w.q.x);
          if (out_if.q_y !== w.q.y) report_mismatch("q_y", out_if.q_y, w.q.y);
          if (out_if.q_z !== w.q.z) report_mismatch("q_z", out_if.q_z, w.q.z);
          if (out_if.r_x !== w.r.x) report_mismatch("r_x", out_if.r_x, w.r.x);
          if (out_if.r_y !== w.r.y) report_mismatch("r_y", out_if.r_y, w.r.y);
          if (out_if.r_z !== w.r.z) report_mismatch("r_z", out_if.r_z, w.r.z);
          if (out_if.last_tri !== w.last_tri)
            report_mismatch("last_tri", out_if.last_tri, w.last_tri);
        end
        mon_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      end
      if (hold_off) begin
        out_if.ready <= 1'b0;
      end else if (mon_gap > 0) begin
        mon_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  function automatic pt_t rand_pt();
    pt_t v;
    v.x = 16'($urandom_range(0, 32768) - 16384);
    v.y = 16'($urandom_range(0, 32768) - 16384);
    v.z = 16'($urandom_range(0, 32768) - 16384);
    return v;
  endfunction

  // roughly unit vector: one axis dominant, the others small
  function automatic pt_t near_unit();
    pt_t v;
    v = '0;
    v.x = 16'($urandom_range(0, 4000) - 2000);
    v.y = 16'($urandom_range(0, 4000) - 2000);
    v.z = 16'($urandom_range(15800, 16384));
    if ($urandom_range(0, 1)) v.z = -v.z;
    case ($urandom_range(0, 2))
      0: ;
      1: v = '{v.z, v.x, v.y};
      default: v = '{v.y, v.z, v.x};
    endcase
    return v;
  endfunction

  function automatic pt_t raw_pt();
    pt_t v;
    v = 48'({$urandom, $urandom});
    return v;
  endfunction

  initial begin
    pt_t px, nx, py, ny, pz, nz, t;
    px = '{16384, 0, 0};  nx = '{-16384, 0, 0};
    py = '{0, 16384, 0};  ny = '{0, -16384, 0};
    pz = '{0, 0, 16384};  nz = '{0, 0, -16384};

    // directed: octahedron faces, cancelling edges, extremes, raw bit patterns
    queue_face('{px, py, pz});
    queue_face('{nx, ny, nz});
    queue_face('{px, nx, py});          // zero-length sum on one edge
    queue_face('{pz, nz, pz});          // two cancelling edges
    queue_face('{'0, '0, '0});          // all zero
    queue_face('{px, px, px});          // degenerate, sums saturate at one
    queue_face('{'{16384, 16384, 16384}, '{-16384, -16384, -16384}, py});
    queue_face('{'{32767, 32767, 32767}, '{32767, 32767, 32767},
                 '{-32768, -32768, -32768}});
    queue_face('{'{-32768, 0, 0}, '{-32768, 0, 0}, '{32767, -1, 1}});
    queue_face('{'{1, 0, 0}, '{0, 1, 0}, '{0, 0, 1}});    // tiny sums
    queue_face('{'{-1, -1, -1}, '{1, 1, 1}, '{16'h5555, 16'haaaa, 16'h00ff}});
    queue_face('{'{16'haaaa, 16'h5555, 16'hff00}, '{16'h0f0f, 16'hf0f0, 16'h7fff},
                 '{16'h8000, 16'h8001, 16'h7ffe}});
    for (int i = 0; i < 6; i++) queue_face('{near_unit(), near_unit(), near_unit()});

    // random part, mostly on-sphere triangles
    for (int i = 0; i < 170; i++) begin
      case ($urandom_range(0, 9))
        0: queue_face('{raw_pt(), raw_pt(), raw_pt()});
        1, 2: queue_face('{rand_pt(), rand_pt(), rand_pt()});
        3: begin
          t = near_unit();
          queue_face('{t, '{-t.x, -t.y, -t.z}, near_unit()});
        end
        default: queue_face('{near_unit(), near_unit(), near_unit()});
      endcase
    end
    stim_done = 1'b1;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && face_q.size() == 0 && !in_if.valid);
    wait (subtri_q.size() == 0);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("[sphere_triangle_subdivider_top] OK");
    end else begin
      $display("[sphere_triangle_subdivider_top] ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout at %0t", $realtime);
    $display("[sphere_triangle_subdivider_top] ERROR");
    $finish;
  end

endmodule
